@@ design/assert_macros.svh @@
// Assertion helpers used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, muted while rst_n is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/fdwt_pkg.sv @@
package fdwt_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned PixW  = 8;
  localparam int unsigned ColW  = 7;
  localparam int unsigned PageW = 2;
  localparam int unsigned PageSlots = 4;

  // Height above this many pixels always uses TallPages pages.
  localparam logic [6:0] TallLimit = 7'd32;
  localparam logic [2:0] TallPages = 3'd4;

  // Register reset values.
  localparam logic [7:0] WidthRst  = 8'd128;
  localparam logic [6:0] HeightRst = 7'd32;

  typedef enum logic [0:0] {
    CFG_DISPLAY_WIDTH  = 1'b0,
    CFG_DISPLAY_HEIGHT = 1'b1
  } cfg_reg_e;

  // One window result, packed with page_index in the lowest bits.
  typedef struct packed {
    logic [ColW-1:0]  last_column;
    logic [ColW-1:0]  first_column;
    logic [PageW-1:0] page_index;
  } win_word_t;

  // Column bytes carry the top pixel in bit 7; the store keeps it in bit 0.
  function automatic logic [PixW-1:0] flip8(input logic [PixW-1:0] b);
    logic [PixW-1:0] r;
    for (int i = 0; i < PixW; i++) begin
      r[i] = b[PixW-1-i];
    end
    return r;
  endfunction

endpackage

@@ design/framebuffer_dirty_window_tracker.sv @@
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] pixel_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[15:0] window, tuser changed, tlast
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i[7:0]
//
// Within a frame one word is accepted every cycle: the store is read at acceptance,
// compared and written back the next cycle, with a one-entry forward for a repeat address.
// The last word of a frame is held off until the windows of the previous frame have all
// moved into the output register. After reset a clearing pass writes zero to all
// MAX_PAGES*MAX_WIDTH store entries with s_axis_tready low; configuration writes are taken.
// A stalled output register stops the word pipeline only at the last word of a frame,
// and only while its window queue still holds windows.

`include "assert_macros.svh"

module framebuffer_dirty_window_tracker import fdwt_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 128,
  parameter int unsigned MAX_PAGES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [PixW-1:0]  s_axis_tdata,   // [7:0] pixel_byte

  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [1:0] page_index, [8:2] first_column,
                                           // [15:9] last_column
  output logic             m_axis_tuser,   // [0] window_changed
  output logic             m_axis_tlast,   // last_window

  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i
);

  localparam int unsigned Depth = MAX_PAGES * MAX_WIDTH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers and the effective geometry derived from them.
  // ---------------------------------------------------------------------------
  logic [7:0] width_q;
  logic [6:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DISPLAY_WIDTH:  width_q  <= cfg_data_i;
        CFG_DISPLAY_HEIGHT: height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [7:0] eff_width;
  logic [2:0] eff_pages;

  always_comb begin
    if (width_q == 8'd0) begin
      eff_width = 8'd1;
    end else if (width_q > 8'(MAX_WIDTH)) begin
      eff_width = 8'(MAX_WIDTH);
    end else begin
      eff_width = width_q;
    end

    // At or below the tall limit the height is at most 32, so bits [5:3] are height/8.
    if (height_q > TallLimit) begin
      eff_pages = TallPages;
    end else begin
      eff_pages = height_q[5:3];
    end
    if (eff_pages == 3'd0) begin
      eff_pages = 3'd1;
    end
    if (eff_pages > 3'(MAX_PAGES)) begin
      eff_pages = 3'(MAX_PAGES);
    end
  end

  // ---------------------------------------------------------------------------
  // Position counters. Pages run inside each column.
  // ---------------------------------------------------------------------------
  logic [PageW-1:0] page_q;
  logic [ColW-1:0]  col_q;
  logic             page_more;
  logic             col_more;
  logic             frame_end_now;
  logic [AddrW-1:0] rd_addr;

  assign page_more     = (({1'b0, page_q} + 3'd1) < eff_pages);
  assign col_more      = (({1'b0, col_q} + 8'd1) < eff_width);
  assign frame_end_now = !page_more && !col_more;

  // Even left past the pages or columns in use, the counters keep the address below Depth.
  assign rd_addr = AddrW'(page_q) * AddrW'(eff_width) + AddrW'(col_q);

  // ---------------------------------------------------------------------------
  // Clearing pass and the accept decision.
  // ---------------------------------------------------------------------------
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  logic       s1_valid_q;
  logic       s1_eof_q;
  logic [3:0] emit_mask_q;
  logic       nochg_q;
  logic       emit_busy;
  logic       in_acc;

  // The frame's last word needs an empty window queue when it reaches the compare stage.
  assign emit_busy     = (|emit_mask_q) || nochg_q || (s1_valid_q && s1_eof_q);
  assign s_axis_tready = !clr_busy_q && !(frame_end_now && emit_busy);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      col_q  <= '0;
    end else if (in_acc) begin
      if (page_more) begin
        page_q <= page_q + 1'b1;
      end else begin
        page_q <= '0;
        col_q  <= col_more ? (col_q + 1'b1) : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Compare stage registers. The store read issued at acceptance lands in rd_byte_q.
  // ---------------------------------------------------------------------------
  logic [PageW-1:0] s1_page_q;
  logic [ColW-1:0]  s1_col_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [PixW-1:0]  s1_byte_q;
  logic             fwd_q;
  logic [PixW-1:0]  fwd_byte_q;
  logic [PixW-1:0]  rd_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_eof_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s1_eof_q   <= in_acc && frame_end_now;
    end
  end

  // The word in the compare stage writes the store at the same edge as this read,
  // so a read of that address would miss it: its byte is forwarded instead.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_page_q  <= page_q;
      s1_col_q   <= col_q;
      s1_addr_q  <= rd_addr;
      s1_byte_q  <= flip8(s_axis_tdata);
      fwd_q      <= s1_valid_q && (s1_addr_q == rd_addr);
      fwd_byte_q <= s1_byte_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store.
  // ---------------------------------------------------------------------------
  logic [PixW-1:0]  store_mem [Depth];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [PixW-1:0]  mem_wdata;

  assign mem_we    = clr_busy_q || s1_valid_q;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : s1_byte_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_byte_q <= store_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Per-page dirty tracking.
  // ---------------------------------------------------------------------------
  logic [3:0]      dirty_q, dirty_d;
  logic [ColW-1:0] first_q [PageSlots];
  logic [ColW-1:0] first_d [PageSlots];
  logic [ColW-1:0] last_q  [PageSlots];
  logic [ColW-1:0] last_d  [PageSlots];
  logic [PixW-1:0] old_byte;
  logic            changed;
  logic            frame_done;

  assign old_byte   = fwd_q ? fwd_byte_q : rd_byte_q;
  assign changed    = s1_valid_q && (s1_byte_q != old_byte);
  assign frame_done = s1_valid_q && s1_eof_q;

  always_comb begin
    dirty_d = dirty_q;
    first_d = first_q;
    last_d  = last_q;
    if (changed) begin
      if (!dirty_q[s1_page_q]) begin
        first_d[s1_page_q] = s1_col_q;
      end
      last_d[s1_page_q]  = s1_col_q;
      dirty_d[s1_page_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= '0;
    end else begin
      dirty_q <= frame_done ? '0 : dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
  end

  // ---------------------------------------------------------------------------
  // Window queue: a snapshot of the dirty pages taken at frame end, drained in
  // ascending page order into the output register.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]  emit_first_q [PageSlots];
  logic [ColW-1:0]  emit_last_q  [PageSlots];
  logic [PageW-1:0] sel_idx;
  logic [3:0]       sel_oh;
  logic             out_load;
  logic             out_valid_q;
  win_word_t        out_word_q;
  logic             out_user_q;
  logic             out_last_q;

  always_comb begin
    sel_idx = '0;
    for (int k = PageSlots - 1; k >= 0; k--) begin
      if (emit_mask_q[k]) begin
        sel_idx = PageW'(k);
      end
    end
    sel_oh = 4'b0001 << sel_idx;
  end

  assign out_load = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_mask_q <= '0;
      nochg_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        if (|emit_mask_q) begin
          out_valid_q <= 1'b1;
          emit_mask_q <= emit_mask_q & ~sel_oh;
        end else if (nochg_q) begin
          out_valid_q <= 1'b1;
          nochg_q     <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
      // The queue is empty whenever a snapshot arrives.
      if (frame_done) begin
        emit_mask_q <= dirty_d;
        nochg_q     <= ~|dirty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      emit_first_q <= first_d;
      emit_last_q  <= last_d;
    end
    if (out_load) begin
      if (|emit_mask_q) begin
        out_word_q.page_index   <= sel_idx;
        out_word_q.first_column <= emit_first_q[sel_idx];
        out_word_q.last_column  <= emit_last_q[sel_idx];
        out_user_q              <= 1'b1;
        out_last_q              <= ((emit_mask_q & ~sel_oh) == 4'd0);
      end else begin
        out_word_q <= '0;
        out_user_q <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_CLK_RST(a_snapshot_into_empty_queue, clk_i, rst_ni,
    frame_done |-> (emit_mask_q == 4'd0 && !nochg_q),
    "frame end snapshot would overwrite pending windows")

  `ASSERT_CLK_RST(a_nochange_is_last, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast,
    "no-change result is not the last result of its frame")

  `ASSERT_CLK(a_no_word_during_clear, clk_i,
    !(clr_busy_q && s1_valid_q),
    "store write from a word while the clearing pass runs")

endmodule

@@ test/tb_framebuffer_dirty_window_tracker.sv @@
`timescale 1ns / 1ps

module tb_framebuffer_dirty_window_tracker;
  import fdwt_pkg::*;

  // Half period, reset and hold lengths, settle time for words closing no frame, run bounds.
  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_WORDS  = 64;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned STORE_DEPTH   = 512;

  // One expected window, held in the order the block reports it.
  typedef struct packed {
    logic [PageW-1:0] page;
    logic [ColW-1:0]  first_col;
    logic [ColW-1:0]  last_col;
    logic             changed;
    logic             closes_frame;
  } window_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_BYTE
  } row_kind_e;

  // A row of the directed table: a register write or a pixel word, and for the
  // simplest one-word frames the window typed in by hand.
  typedef struct packed {
    row_kind_e  kind;
    cfg_reg_e   reg_sel;
    logic [7:0] value;
    logic       typed;
    window_t    want;
  } stim_row_t;

  localparam window_t NO_CHANGE  = '{2'd0, 7'd0, 7'd0, 1'b0, 1'b1};
  localparam window_t COL0_DIRTY = '{2'd0, 7'd0, 7'd0, 1'b1, 1'b1};

  // The first rows run one-word frames on a single page and column, where the
  // window is obvious. Then a four-page frame, a frame cut by a height change
  // while the page counter sits past the new last page, and a frame cut by a
  // width change while the column counter sits past the new last column.
  localparam stim_row_t DIRECTED_ROWS [32] = '{
    '{ROW_REG,  CFG_DISPLAY_WIDTH,  8'd1,   1'b0, NO_CHANGE},
    '{ROW_REG,  CFG_DISPLAY_HEIGHT, 8'd8,   1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b1, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h80,  1'b1, COL0_DIRTY},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h80,  1'b1, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'hFF,  1'b1, COL0_DIRTY},
    '{ROW_REG,  CFG_DISPLAY_WIDTH,  8'd0,   1'b0, NO_CHANGE},
    '{ROW_REG,  CFG_DISPLAY_HEIGHT, 8'd0,   1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'hFF,  1'b1, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b1, COL0_DIRTY},
    '{ROW_REG,  CFG_DISPLAY_WIDTH,  8'd2,   1'b0, NO_CHANGE},
    '{ROW_REG,  CFG_DISPLAY_HEIGHT, 8'hFF,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h01,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h00,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h80,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'hAA,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h55,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'hC3,  1'b0, NO_CHANGE},
    '{ROW_REG,  CFG_DISPLAY_HEIGHT, 8'd8,   1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h3C,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h7E,  1'b0, NO_CHANGE},
    '{ROW_REG,  CFG_DISPLAY_WIDTH,  8'hFF,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h0F,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'hF0,  1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h99,  1'b0, NO_CHANGE},
    '{ROW_REG,  CFG_DISPLAY_WIDTH,  8'd2,   1'b0, NO_CHANGE},
    '{ROW_BYTE, CFG_DISPLAY_WIDTH,  8'h66,  1'b0, NO_CHANGE}
  };

  // Every input starts at a known value; reset is held low from time zero.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PixW-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;   // [1:0] page_index, [8:2] first_column, [15:9] last_column
  logic             m_axis_tuser;   // [0] window_changed
  logic             m_axis_tlast;
  logic             cfg_we_i      = 1'b0;
  logic [0:0]       cfg_idx_i     = CFG_DISPLAY_WIDTH;
  logic [7:0]       cfg_data_i    = '0;

  // Shared between the word sender, the window receiver, the window checker and the hard stop.
  window_t pending_windows [$];
  window_t frame_windows [$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      words_sent     = 0;
  bit      gaps_on        = 1'b0;
  bit      stalls_on      = 1'b0;
  bit      long_hold      = 1'b0;

  // Our own copy of the block's state: the frame store, the per-page dirty
  // windows, the scan counters and the two registers.
  logic [7:0]       screen_copy [STORE_DEPTH];
  logic             page_touched [PageSlots];
  logic [ColW-1:0]  touched_first [PageSlots];
  logic [ColW-1:0]  touched_last [PageSlots];
  logic [ColW-1:0]  scan_col;
  logic [PageW-1:0] scan_page;
  logic [7:0]       width_reg;
  logic [6:0]       height_reg;

  framebuffer_dirty_window_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs on either handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The store keeps the top pixel in bit 0, the stream carries it in bit 7.
  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  // A width of zero still scans one column; anything past 128 is clamped.
  function automatic int unsigned cols_in_use();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > 128) w = 128;
    return w;
  endfunction

  // Tall panels always use four pages; short ones still use at least one.
  function automatic int unsigned pages_in_use();
    int unsigned p;
    p = (height_reg > 7'd32) ? 4 : height_reg / 8;
    if (p == 0) p = 1;
    if (p > PageSlots) p = PageSlots;
    return p;
  endfunction

  function automatic int unsigned scan_addr();
    return (scan_page * cols_in_use() + scan_col) % STORE_DEPTH;
  endfunction

  function automatic void reset_shadow();
    foreach (screen_copy[i]) screen_copy[i] = '0;
    for (int k = 0; k < PageSlots; k++) begin
      page_touched[k]  = 1'b0;
      touched_first[k] = '0;
      touched_last[k]  = '0;
    end
    scan_col   = '0;
    scan_page  = '0;
    width_reg  = WidthRst;
    height_reg = HeightRst;
  endfunction

  // Works through one accepted pixel word. The windows it closes, if any, are
  // left in frame_windows in the order the block must report them.
  function automatic void track_pixel_byte(input logic [7:0] pix);
    int unsigned w;
    int unsigned pages;
    int unsigned addr;
    logic [7:0]  stored;
    window_t     win;

    w      = cols_in_use();
    pages  = pages_in_use();
    addr   = scan_addr();
    stored = mirror_byte(pix);
    frame_windows.delete();

    if (stored != screen_copy[addr]) begin
      if (!page_touched[scan_page]) begin
        page_touched[scan_page]  = 1'b1;
        touched_first[scan_page] = scan_col;
      end
      touched_last[scan_page] = scan_col;
    end
    screen_copy[addr] = stored;

    // A page counter past the last page (left there by a height change) wraps
    // like the last page does, and a column past the last one ends the frame.
    if (scan_page + 1 < pages) begin
      scan_page = scan_page + 1'b1;
      return;
    end
    scan_page = '0;
    if (scan_col + 1 < w) begin
      scan_col = scan_col + 1'b1;
      return;
    end
    scan_col = '0;

    for (int k = 0; k < PageSlots; k++) begin
      if (page_touched[k]) begin
        win.page         = PageW'(k);
        win.first_col    = touched_first[k];
        win.last_col     = touched_last[k];
        win.changed      = 1'b1;
        win.closes_frame = 1'b0;
        frame_windows.push_back(win);
      end
      page_touched[k] = 1'b0;
    end
    if (frame_windows.size() == 0) begin
      frame_windows.push_back(NO_CHANGE);
    end else begin
      frame_windows[frame_windows.size()-1].closes_frame = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Register writes go in only while nothing is in flight; the wait that follows with
  // the enable low keeps back-to-back writes apart.
  task automatic write_reg(input cfg_reg_e sel, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    if (sel == CFG_DISPLAY_WIDTH) begin
      width_reg = data;
    end else begin
      height_reg = data[6:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one pixel word, possibly after a random gap, and books its windows
  // once it is taken. Typed rows replace the predicted window with their own.
  task automatic push_byte(input logic [7:0] pix, input logic typed, input window_t want);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    track_pixel_byte(pix);
    if (typed) begin
      pending_windows.push_back(want);
    end else begin
      foreach (frame_windows[i]) pending_windows.push_back(frame_windows[i]);
    end
    words_sent++;
  endtask

  // Stops offering words, waits for every booked window, then lets the tail of
  // the pipeline empty, since words that close no frame leave no trace.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The density sets how many of eight words, on average, are drawn at random; the
  // rest repeat what the store already holds at that spot, so frames range from
  // untouched to fully redrawn.
  function automatic logic [7:0] pick_byte(input int unsigned density);
    if ($urandom_range(0, 7) < density) return 8'($urandom_range(0, 255));
    return mirror_byte(screen_copy[scan_addr()]);
  endfunction

  task automatic send_frame(input int unsigned density);
    do begin
      push_byte(pick_byte(density), 1'b0, NO_CHANGE);
    end while (frame_windows.size() == 0);
  endtask

  function automatic logic [7:0] pick_height();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 7));
      1:       return 8'($urandom_range(8, 15));
      2:       return 8'($urandom_range(16, 31));
      3:       return 8'd32;
      4:       return 8'($urandom_range(33, 127));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 4;
      3:       return 8;
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_start;
    int unsigned frames;

    reset_shadow();
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed table. Register rows wait for the block to go idle first; the
    // clearing pass after reset simply shows up as a long first tready low.
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_REG) begin
        settle_block();
        write_reg(DIRECTED_ROWS[i].reg_sel, DIRECTED_ROWS[i].value);
      end else begin
        push_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end

    // Backpressure: one-word frames keep producing windows while the receiver
    // holds off, so the window queue fills and the block must stall its input.
    settle_block();
    write_reg(CFG_DISPLAY_WIDTH, 8'd1);
    write_reg(CFG_DISPLAY_HEIGHT, 8'd8);
    long_hold = 1'b1;
    repeat (12) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_CHANGE);
    settle_block();

    // Random phases: a fresh small geometry each time, one or two whole frames of
    // varied change density, and now and then a frame left half done so the
    // next geometry picks up the stale counters.
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      settle_block();
      write_reg(CFG_DISPLAY_WIDTH, 8'($urandom_range(0, 8)));
      write_reg(CFG_DISPLAY_HEIGHT, pick_height());
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      frames    = $urandom_range(1, 2);
      repeat (frames) send_frame(pick_density());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(pick_byte(4), 1'b0, NO_CHANGE);
      end
    end

    // Quiet tail: one two-page frame with no idling on either side.
    settle_block();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(CFG_DISPLAY_WIDTH, 8'd8);
    write_reg(CFG_DISPLAY_HEIGHT, 8'd16);
    send_frame(4);
    settle_block();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  // Random stall bursts, plus one long hold-off counted here on request.
  initial begin : receiver
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every accepted window is matched against the oldest booked one.
  always @(posedge clk_i) begin : window_check
    win_word_t got;
    window_t   want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = win_word_t'(m_axis_tdata);
      if (pending_windows.size() == 0) begin
        $error("unexpected window word: tdata=%h tuser=%b tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_windows.pop_front();
        if (got.page_index !== want.page) begin
          $error("page_index: expected %0d, got %0d", want.page, got.page_index);
          mismatch_count++;
        end
        if (got.first_column !== want.first_col) begin
          $error("first_column: expected %0d, got %0d", want.first_col, got.first_column);
          mismatch_count++;
        end
        if (got.last_column !== want.last_col) begin
          $error("last_column: expected %0d, got %0d", want.last_col, got.last_column);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.changed) begin
          $error("window_changed: expected %0b, got %0b", want.changed, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.closes_frame) begin
          $error("last_window: expected %0b, got %0b", want.closes_frame, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

endmodule

@@ filelist.f @@
+incdir+design
design/fdwt_pkg.sv
design/framebuffer_dirty_window_tracker.sv
test/tb_framebuffer_dirty_window_tracker.sv
